FILE: rtl/sliding_window_rms_assert.svh
// assertion macros for the sliding window rms block
// expects clk and rst_n in the scope of each use
`ifndef SLIDING_WINDOW_RMS_ASSERT_SVH
`define SLIDING_WINDOW_RMS_ASSERT_SVH
`ifndef SYNTHESIS
`define SWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SWR_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define SWR_ASSERT(lbl, prop, msg)
`define SWR_ASSERT_IMPLIES(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/swr_pkg.sv
// shared types and constants for the sliding window rms block
// no dependencies
package swr_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int RMS_W      = 12;
  localparam int LEN_W      = 11;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int SQ_W       = 16;
  localparam int K_W        = 26;
  localparam int SUM_SPLIT  = 16;
  localparam int A_W        = 27;
  localparam int A_SPLIT    = 14;
  localparam int ODD_W      = 13;
  localparam int ODD2_W     = 26;

  localparam logic [LEN_W-1:0]    LEN_RESET     = 11'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd1001;
  localparam logic [RMS_W-1:0]    FULL_SCALE_MV = 12'd3300;
  localparam logic [SQ_W-1:0]     CODE_SQ       = 16'd65025;
  // 4 * 3300^2
  localparam logic [K_W-1:0]      RHS_K         = 26'd43560000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN    = 1'b0,
    CFG_REPORT_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQUARE = 8'b0000_0010,
    ST_UPDATE = 8'b0000_0100,
    ST_BPROD  = 8'b0000_1000,
    ST_BSUM   = 8'b0001_0000,
    ST_ODD    = 8'b0010_0000,
    ST_MUL    = 8'b0100_0000,
    ST_CMP    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic update;
    logic bprod;
    logic bsum;
    logic odd;
    logic mul;
    logic cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic report;
    logic done;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/swr_if.sv
// sample and result channel interfaces
// depends on swr_pkg
interface swr_in_if;
  logic                          valid;
  logic                          ready;
  logic [swr_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swr_out_if;
  logic                       valid;
  logic                       ready;
  logic [swr_pkg::RMS_W-1:0] rms_millivolts;
  modport source (output valid, output rms_millivolts, input ready);
  modport sink   (input valid, input rms_millivolts, output ready);
endinterface

FILE: rtl/swr_ctrl.sv
// sequencing state machine: sample update and square root search
// depends on swr_pkg
module swr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swr_pkg::status_t  status,
  output swr_pkg::cmd_t     cmd
);

  swr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      swr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = swr_pkg::ST_SQUARE;
        end
      end
      swr_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = swr_pkg::ST_UPDATE;
      end
      swr_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = status.report ? swr_pkg::ST_BPROD : swr_pkg::ST_IDLE;
      end
      swr_pkg::ST_BPROD: begin
        cmd.bprod = 1'b1;
        state_nxt = swr_pkg::ST_BSUM;
      end
      swr_pkg::ST_BSUM: begin
        cmd.bsum  = 1'b1;
        state_nxt = swr_pkg::ST_ODD;
      end
      swr_pkg::ST_ODD: begin
        if (status.done) begin
          if (!status.out_busy) begin
            cmd.emit  = 1'b1;
            state_nxt = swr_pkg::ST_IDLE;
          end
        end else begin
          cmd.odd   = 1'b1;
          state_nxt = swr_pkg::ST_MUL;
        end
      end
      swr_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = swr_pkg::ST_CMP;
      end
      swr_pkg::ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = swr_pkg::ST_ODD;
      end
      default: begin
        state_nxt = swr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/swr_datapath.sv
// window store, sum of squares, report counter and rms search datapath
// depends on swr_pkg and sliding_window_rms_assert.svh
`include "sliding_window_rms_assert.svh"

module swr_datapath #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  swr_pkg::cmd_t                    cmd,
  output swr_pkg::status_t                 status,
  input  logic [swr_pkg::SAMPLE_W-1:0]     sample_in,
  input  logic                             cfg_we,
  input  logic [swr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [swr_pkg::RMS_W-1:0]        out_data
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam logic [63:0] SUM_MAX = 64'(WINDOW_MAX) * 64'(swr_pkg::CODE_SQ);
  localparam int SW   = $clog2(SUM_MAX + 64'd1);
  localparam int BL_W = swr_pkg::K_W + swr_pkg::SUM_SPLIT;
  localparam int BH_W = swr_pkg::K_W + SW - swr_pkg::SUM_SPLIT;
  localparam int BW   = swr_pkg::K_W + SW;
  localparam int PL_W = swr_pkg::ODD2_W + swr_pkg::A_SPLIT;
  localparam int PH_W = swr_pkg::ODD2_W + swr_pkg::A_W - swr_pkg::A_SPLIT;
  localparam int LW   = swr_pkg::ODD2_W + swr_pkg::A_W;
  localparam int CW   = (BW > LW) ? BW : LW;

  logic [swr_pkg::SAMPLE_W-1:0] mem [WINDOW_MAX];

  logic [swr_pkg::LEN_W-1:0]    window_len_r;
  logic [swr_pkg::PERIOD_W-1:0] period_r;
  logic [SW-1:0]                sum_r;
  logic [AW-1:0]                write_pos_r;
  logic                         full_r;
  logic [swr_pkg::PERIOD_W-1:0] report_count_r;
  logic                         out_valid_r;
  logic [swr_pkg::RMS_W-1:0]    out_data_r;
  logic [swr_pkg::RMS_W-1:0]    lo_r, hi_r, mid_r;

  logic [swr_pkg::SAMPLE_W-1:0] sample_r, rd_data_r;
  logic [AW-1:0]                pos_r;
  logic [swr_pkg::SQ_W-1:0]     oldsq_r, newsq_r;
  logic [BL_W-1:0]              bl_r;
  logic [BH_W-1:0]              bh_r;
  logic [BW-1:0]                b_r;
  logic [swr_pkg::A_W-1:0]      a_r;
  logic [swr_pkg::ODD2_W-1:0]   odd2_r;
  logic [PL_W-1:0]              pl_r;
  logic [PH_W-1:0]              ph_r;

  logic [swr_pkg::LEN_W-1:0]    n_eff;
  logic [swr_pkg::PERIOD_W-1:0] period_eff;
  logic [AW-1:0]                pos_in;
  logic [SW-1:0]                sum_sub;
  logic                         pos_wrap;
  logic                         report;
  logic [swr_pkg::RMS_W-1:0]    span, mid;
  logic [swr_pkg::ODD_W-1:0]    odd;
  logic [LW-1:0]                lhs;
  logic                         fits;

  always_comb begin
    if (window_len_r == '0) begin
      n_eff = swr_pkg::LEN_W'(1);
    end else if (32'(window_len_r) > WINDOW_MAX) begin
      n_eff = swr_pkg::LEN_W'(WINDOW_MAX);
    end else begin
      n_eff = window_len_r;
    end
    period_eff = (period_r == '0) ? swr_pkg::PERIOD_W'(1) : period_r;
    report     = ({1'b0, report_count_r} + 17'd1) >= {1'b0, period_eff};
    pos_in     = (32'(write_pos_r) >= 32'(n_eff)) ? '0 : write_pos_r;
    pos_wrap   = (32'(pos_r) + 32'd1) >= 32'(n_eff);
    if (full_r) begin
      sum_sub = (sum_r >= SW'(oldsq_r)) ? sum_r - SW'(oldsq_r) : '0;
    end else begin
      sum_sub = sum_r;
    end
    span = hi_r - lo_r + swr_pkg::RMS_W'(1);
    mid  = lo_r + (span >> 1);
    odd  = {mid, 1'b0} - swr_pkg::ODD_W'(1);
    lhs  = {ph_r, {swr_pkg::A_SPLIT{1'b0}}} + LW'(pl_r);
    fits = CW'(lhs) <= CW'(b_r);
  end

  assign status.report   = report;
  assign status.done     = (lo_r == hi_r);
  assign status.out_busy = out_valid_r & ~out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // window store, registered read
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[pos_r] <= sample_r;
    end
    if (cmd.load) begin
      rd_data_r <= mem[pos_in];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r   <= swr_pkg::LEN_RESET;
      period_r       <= swr_pkg::PERIOD_RESET;
      sum_r          <= '0;
      write_pos_r    <= '0;
      full_r         <= 1'b0;
      report_count_r <= '0;
      out_valid_r    <= 1'b0;
      lo_r           <= '0;
      hi_r           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (swr_pkg::cfg_idx_t'(cfg_index))
          swr_pkg::CFG_WINDOW_LEN: begin
            window_len_r <= cfg_data[swr_pkg::LEN_W-1:0];
            sum_r        <= '0;
            write_pos_r  <= '0;
            full_r       <= 1'b0;
          end
          swr_pkg::CFG_REPORT_PERIOD: begin
            period_r <= cfg_data[swr_pkg::PERIOD_W-1:0];
          end
        endcase
      end
      if (cmd.update) begin
        sum_r <= sum_sub + SW'(newsq_r);
        if (pos_wrap) begin
          write_pos_r <= '0;
          full_r      <= 1'b1;
        end else begin
          write_pos_r <= pos_r + AW'(1);
        end
        report_count_r <= report ? '0 : report_count_r + swr_pkg::PERIOD_W'(1);
      end
      if (cmd.bprod) begin
        lo_r <= '0;
        hi_r <= swr_pkg::FULL_SCALE_MV;
      end
      if (cmd.cmp) begin
        if (fits) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r - swr_pkg::RMS_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample_in;
      pos_r    <= pos_in;
    end
    if (cmd.square) begin
      oldsq_r <= swr_pkg::SQ_W'(rd_data_r) * swr_pkg::SQ_W'(rd_data_r);
      newsq_r <= swr_pkg::SQ_W'(sample_r) * swr_pkg::SQ_W'(sample_r);
    end
    if (cmd.bprod) begin
      bl_r <= BL_W'(swr_pkg::RHS_K) * BL_W'(sum_r[swr_pkg::SUM_SPLIT-1:0]);
      bh_r <= BH_W'(swr_pkg::RHS_K) * BH_W'(sum_r[SW-1:swr_pkg::SUM_SPLIT]);
      a_r  <= swr_pkg::A_W'(swr_pkg::CODE_SQ) * swr_pkg::A_W'(n_eff);
    end
    if (cmd.bsum) begin
      b_r <= {bh_r, {swr_pkg::SUM_SPLIT{1'b0}}} + BW'(bl_r);
    end
    if (cmd.odd) begin
      mid_r  <= mid;
      odd2_r <= swr_pkg::ODD2_W'(odd) * swr_pkg::ODD2_W'(odd);
    end
    if (cmd.mul) begin
      pl_r <= PL_W'(odd2_r) * PL_W'(a_r[swr_pkg::A_SPLIT-1:0]);
      ph_r <= PH_W'(odd2_r) * PH_W'(a_r[swr_pkg::A_W-1:swr_pkg::A_SPLIT]);
    end
    if (cmd.emit) begin
      out_data_r <= lo_r;
    end
  end

  `SWR_ASSERT(a_search_order, lo_r <= hi_r, "search bounds crossed")
  `SWR_ASSERT(a_search_cap, hi_r <= swr_pkg::FULL_SCALE_MV, "search bound above full scale")
  `SWR_ASSERT(a_pos_in_window, 32'(write_pos_r) < 32'(n_eff), "write position outside window")
  `SWR_ASSERT_IMPLIES(a_emit_converged, cmd.emit, lo_r == hi_r, "result sent before search end")

endmodule

FILE: rtl/sliding_window_rms.sv
// sliding window rms meter, top level: controller plus datapath
// a sample is taken in idle, squared and added to the window sum; a reporting sample then
// forms the bound and runs at most 12 square root search steps (odd, multiply, compare)
// and waits for a free output; a new sample is taken only once the block is back in idle
// reset: synchronous active low, clears sums, counters and config to defaults;
// the window store is not cleared and needs no clearing pass
module sliding_window_rms #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  swr_in_if.sink                         in_chan,
  swr_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0] cfg_data
);

  swr_pkg::cmd_t    cmd;
  swr_pkg::status_t status;

  swr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swr_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .sample_in (in_chan.sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.rms_millivolts)
  );

endmodule
